FILE: hdl/hmnt_pkg.sv
// ----------------------------------------------------------------------------
// hmnt_pkg
// Types, state encodings and constants shared by the heightmap normal and
// tangent core.
// ----------------------------------------------------------------------------
package hmnt_pkg;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;

    localparam logic [8:0] GRID_RESET = 9'd256;
    localparam logic [8:0] GRID_MIN   = 9'd2;

    localparam int QUEUE_DEPTH = 2;

    // y = round(byte * 12288 / 100), division done by reciprocal
    localparam logic [13:0] POS_SCALE = 14'd12288;
    localparam logic [5:0]  POS_ROUND = 6'd50;
    localparam logic [22:0] POS_RECIP = 23'd5368710;
    localparam int          POS_SHIFT = 29;

    localparam logic signed [31:0] VEC_Y_FACE = 32'sd100;
    localparam logic signed [31:0] VEC_X_TAN  = 32'sd100;
    localparam logic signed [17:0] ACC_Y_INIT = 18'sd16384;
    localparam logic [15:0]        Q_ONE      = 16'd16384;

    typedef logic signed [31:0] wide_t;
    typedef logic signed [15:0] comp_t;

    typedef struct packed {
        logic       func;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] height;
        logic       bad;
        logic [8:0] rows;
        logic [8:0] cols;
    } item_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_READ, BK_FACE, BK_FWAIT, BK_ACC, BK_AWAIT,
        BK_TAN, BK_TWAIT, BK_CROSS, BK_BIN, BK_BWAIT
    } bk_state_t;

    typedef enum logic [2:0] {
        NU_IDLE, NU_SHIFT, NU_SQR, NU_SQRT, NU_LOAD, NU_DIV, NU_DONE
    } nu_state_t;

endpackage

FILE: hdl/hmnt_front.sv
// ----------------------------------------------------------------------------
// hmnt_front
// Accepts items and configuration writes, saturates the grid size and flags
// queries that fall outside the grid.
// ----------------------------------------------------------------------------
module hmnt_front #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                func,
    input  logic [7:0]          row,
    input  logic [7:0]          col,
    input  logic [7:0]          height_byte,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    input  logic                full,
    output logic                push,
    output hmnt_pkg::item_t     item
);

    logic [8:0] cols_reg;
    logic [8:0] rows_reg;
    logic [8:0] cols_sat;
    logic [8:0] rows_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cols_reg <= hmnt_pkg::GRID_RESET;
            rows_reg <= hmnt_pkg::GRID_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hmnt_pkg::CFG_COLUMNS: cols_reg <= cfg_data;
                hmnt_pkg::CFG_ROWS:    rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (cols_reg < hmnt_pkg::GRID_MIN) begin
            cols_sat = hmnt_pkg::GRID_MIN;
        end else if (32'(cols_reg) > MAX_COLUMNS) begin
            cols_sat = 9'(MAX_COLUMNS);
        end else begin
            cols_sat = cols_reg;
        end
        if (rows_reg < hmnt_pkg::GRID_MIN) begin
            rows_sat = hmnt_pkg::GRID_MIN;
        end else if (32'(rows_reg) > MAX_ROWS) begin
            rows_sat = 9'(MAX_ROWS);
        end else begin
            rows_sat = rows_reg;
        end
    end

    assign push = start && !full;

    always_comb begin
        item.func   = func;
        item.row    = row;
        item.col    = col;
        item.height = height_byte;
        item.bad    = ({1'b0, row} >= rows_sat) || ({1'b0, col} >= cols_sat);
        item.rows   = rows_sat;
        item.cols   = cols_sat;
    end

endmodule

FILE: hdl/hmnt_fifo.sv
// ----------------------------------------------------------------------------
// hmnt_fifo
// Short item queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hmnt_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hmnt_pkg::item_t din,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output hmnt_pkg::item_t dout
);

    localparam int DEPTH = hmnt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    hmnt_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push lost");
`endif

endmodule

FILE: hdl/hmnt_norm.sv
// ----------------------------------------------------------------------------
// hmnt_norm
// Shared vector normalizer: scales a 3-vector to Q1.14 unit length with a
// bit-serial square root and a restoring divider.
// ----------------------------------------------------------------------------
module hmnt_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  hmnt_pkg::wide_t vec_in [3],
    output logic            done,
    output hmnt_pkg::comp_t vec_out [3]
);

    hmnt_pkg::nu_state_t state_reg, state_next;

    logic [31:0]     m_reg [3];
    logic [2:0]      neg_reg;
    logic [31:0]     mx_reg;
    logic [31:0]     n2_reg;
    logic [63:0]     n_reg;
    logic [63:0]     res_reg;
    logic [63:0]     bit_reg;
    logic [47:0]     rem_reg;
    logic [15:0]     q_reg;
    logic [1:0]      comp_reg;
    logic [3:0]      bpos_reg;
    hmnt_pkg::comp_t o_reg [3];

    logic [31:0] abs_in [3];
    logic [31:0] mx_in;
    logic [29:0] sq;
    logic [31:0] n2_sum;
    logic [63:0] sqrt_trial;
    logic        sqrt_take;
    logic [63:0] res_nx;
    logic [47:0] dsh;
    logic        div_take;
    logic [15:0] q_nx;
    logic [15:0] q_cap;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            abs_in[k] = vec_in[k][31] ? 32'(-vec_in[k]) : 32'(vec_in[k]);
        end
        mx_in = abs_in[0];
        if (abs_in[1] > mx_in) mx_in = abs_in[1];
        if (abs_in[2] > mx_in) mx_in = abs_in[2];
    end

    assign sq         = m_reg[comp_reg][14:0] * m_reg[comp_reg][14:0];
    assign n2_sum     = n2_reg + 32'(sq);
    assign sqrt_trial = res_reg + bit_reg;
    assign sqrt_take  = n_reg >= sqrt_trial;
    assign res_nx     = sqrt_take ? (res_reg >> 1) + bit_reg : res_reg >> 1;
    assign dsh        = 48'({res_reg[30:0], 1'b0}) << bpos_reg;
    assign div_take   = rem_reg >= dsh;
    assign q_nx       = div_take ? (q_reg | (16'd1 << bpos_reg)) : q_reg;
    assign q_cap      = (q_nx > hmnt_pkg::Q_ONE) ? hmnt_pkg::Q_ONE : q_nx;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= hmnt_pkg::NU_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        unique case (state_reg)
            hmnt_pkg::NU_IDLE: begin
                if (start) begin
                    state_next = (mx_in == '0) ? hmnt_pkg::NU_DONE : hmnt_pkg::NU_SHIFT;
                end
            end
            hmnt_pkg::NU_SHIFT: begin
                if (mx_reg < 32'd32768 && mx_reg >= 32'd16384) begin
                    state_next = hmnt_pkg::NU_SQR;
                end
            end
            hmnt_pkg::NU_SQR: begin
                if (comp_reg == 2'd2) state_next = hmnt_pkg::NU_SQRT;
            end
            hmnt_pkg::NU_SQRT: begin
                if (bit_reg[0]) state_next = hmnt_pkg::NU_LOAD;
            end
            hmnt_pkg::NU_LOAD: state_next = hmnt_pkg::NU_DIV;
            hmnt_pkg::NU_DIV: begin
                if (bpos_reg == '0) begin
                    state_next = (comp_reg == 2'd2) ? hmnt_pkg::NU_DONE : hmnt_pkg::NU_LOAD;
                end
            end
            hmnt_pkg::NU_DONE: begin
                done       = 1'b1;
                state_next = hmnt_pkg::NU_IDLE;
            end
            default: state_next = hmnt_pkg::NU_IDLE;
        endcase
    end

    always_ff @(posedge clk) begin
        case (state_reg)
            hmnt_pkg::NU_IDLE: begin
                if (start) begin
                    for (int k = 0; k < 3; k++) begin
                        m_reg[k]   <= abs_in[k];
                        neg_reg[k] <= vec_in[k][31];
                        if (mx_in == '0) o_reg[k] <= '0;
                    end
                    mx_reg   <= mx_in;
                    n2_reg   <= '0;
                    comp_reg <= '0;
                end
            end
            hmnt_pkg::NU_SHIFT: begin
                // right shifts truncate each component on its own
                if (mx_reg >= 32'd32768) begin
                    for (int k = 0; k < 3; k++) m_reg[k] <= m_reg[k] >> 1;
                    mx_reg <= mx_reg >> 1;
                end else if (mx_reg < 32'd16384) begin
                    for (int k = 0; k < 3; k++) m_reg[k] <= m_reg[k] << 1;
                    mx_reg <= mx_reg << 1;
                end
            end
            hmnt_pkg::NU_SQR: begin
                n2_reg   <= n2_sum;
                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                if (comp_reg == 2'd2) begin
                    n_reg   <= {4'b0, n2_sum, 28'b0};
                    res_reg <= '0;
                    bit_reg <= 64'd1 << 62;
                end
            end
            hmnt_pkg::NU_SQRT: begin
                if (sqrt_take) n_reg <= n_reg - sqrt_trial;
                res_reg <= res_nx;
                bit_reg <= bit_reg >> 2;
            end
            hmnt_pkg::NU_LOAD: begin
                rem_reg  <= (48'(m_reg[comp_reg][14:0]) << 29) + 48'(res_reg[30:0]);
                q_reg    <= '0;
                bpos_reg <= 4'd15;
            end
            hmnt_pkg::NU_DIV: begin
                if (div_take) rem_reg <= rem_reg - dsh;
                q_reg    <= q_nx;
                bpos_reg <= bpos_reg - 4'd1;
                if (bpos_reg == '0) begin
                    o_reg[comp_reg] <= neg_reg[comp_reg] ? -$signed(q_cap) : $signed(q_cap);
                    comp_reg        <= comp_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign vec_out = o_reg;

endmodule

FILE: hdl/hmnt_back.sv
// ----------------------------------------------------------------------------
// hmnt_back
// Height store and query sequencer: gathers the 3x3 neighborhood, sums the
// face normals, then derives normal, tangent and binormal.
// ----------------------------------------------------------------------------
module hmnt_back #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    input  hmnt_pkg::item_t entry,
    output logic            pop,
    output logic            out_valid,
    output logic [14:0]     pos_y,
    output hmnt_pkg::comp_t normal [3],
    output hmnt_pkg::comp_t tangent [3],
    output hmnt_pkg::comp_t binormal [3],
    output logic            bad_query
);

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    hmnt_pkg::bk_state_t state_reg, state_next;

    logic [7:0]             mem [DEPTH];
    logic [7:0]             rdata_reg;
    hmnt_pkg::item_t        cur_reg;
    logic [3:0]             cnt_reg;
    logic [7:0]             h_reg [9];
    logic signed [17:0]     acc_reg [3];
    logic signed [12:0]     tdy_reg;
    hmnt_pkg::comp_t        nrm_reg [3];
    hmnt_pkg::comp_t        tan_reg [3];
    hmnt_pkg::comp_t        bin_reg [3];
    hmnt_pkg::wide_t        cr_reg [3];
    hmnt_pkg::wide_t        prod_reg;
    logic [44:0]            pos_prod_reg;
    logic [14:0]            pos_reg;
    logic                   out_valid_reg;
    logic                   bad_reg;

    logic                   mem_we;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [1:0]             dr;
    logic [1:0]             dc;
    logic [9:0]             nr;
    logic [9:0]             nc;

    logic                   up;
    logic                   left;
    logic                   tri2;
    logic [7:0]             h00, h01, h10, h11;
    logic                   face_ok;
    logic signed [12:0]     s00, s01, s10, s11, d1, d2, d3;
    logic signed [12:0]     fx, fz, fdy;

    logic                   nu_start;
    logic                   nu_done;
    hmnt_pkg::wide_t        nu_vec [3];
    hmnt_pkg::comp_t        nu_out [3];
    hmnt_pkg::comp_t        pa, pb;
    logic [1:0]             cr_idx;
    logic [21:0]            pos_x;

    // store write for loads, ignored outside the store
    assign wr_addr = AW'(32'(entry.row) * MAX_COLUMNS + 32'(entry.col));
    assign mem_we  = valid && (state_reg == hmnt_pkg::BK_IDLE)
                     && (entry.func == hmnt_pkg::FUNC_LOAD)
                     && (32'(entry.row) < MAX_ROWS) && (32'(entry.col) < MAX_COLUMNS);

    always_comb begin
        case (cnt_reg)
            4'd0:    begin dr = 2'd0; dc = 2'd0; end
            4'd1:    begin dr = 2'd0; dc = 2'd1; end
            4'd2:    begin dr = 2'd0; dc = 2'd2; end
            4'd3:    begin dr = 2'd1; dc = 2'd0; end
            4'd4:    begin dr = 2'd1; dc = 2'd1; end
            4'd5:    begin dr = 2'd1; dc = 2'd2; end
            4'd6:    begin dr = 2'd2; dc = 2'd0; end
            4'd7:    begin dr = 2'd2; dc = 2'd1; end
            default: begin dr = 2'd2; dc = 2'd2; end
        endcase
        nr = 10'(cur_reg.row) + 10'(dr) - 10'd1;
        nc = 10'(cur_reg.col) + 10'(dc) - 10'd1;
        // neighbors outside the store are never used
        if (32'(nr) < MAX_ROWS && 32'(nc) < MAX_COLUMNS) begin
            rd_addr = AW'(32'(nr) * MAX_COLUMNS + 32'(nc));
        end else begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[wr_addr] <= entry.height;
        end
        rdata_reg <= mem[rd_addr];
    end

    // adjacent triangle k: cell offset and corner heights from the 3x3 window
    always_comb begin
        case (cnt_reg[2:0])
            3'd0:    begin up = 1'b1; left = 1'b1; tri2 = 1'b0;
                           h00 = h_reg[0]; h01 = h_reg[1]; h10 = h_reg[3]; h11 = h_reg[4]; end
            3'd1:    begin up = 1'b1; left = 1'b1; tri2 = 1'b1;
                           h00 = h_reg[0]; h01 = h_reg[1]; h10 = h_reg[3]; h11 = h_reg[4]; end
            3'd2:    begin up = 1'b1; left = 1'b0; tri2 = 1'b1;
                           h00 = h_reg[1]; h01 = h_reg[2]; h10 = h_reg[4]; h11 = h_reg[5]; end
            3'd3:    begin up = 1'b0; left = 1'b1; tri2 = 1'b0;
                           h00 = h_reg[3]; h01 = h_reg[4]; h10 = h_reg[6]; h11 = h_reg[7]; end
            3'd4:    begin up = 1'b0; left = 1'b0; tri2 = 1'b0;
                           h00 = h_reg[4]; h01 = h_reg[5]; h10 = h_reg[7]; h11 = h_reg[8]; end
            default: begin up = 1'b0; left = 1'b0; tri2 = 1'b1;
                           h00 = h_reg[4]; h01 = h_reg[5]; h10 = h_reg[7]; h11 = h_reg[8]; end
        endcase
        face_ok = (up ? (cur_reg.row != '0) : (10'(cur_reg.row) + 10'd2 <= 10'(cur_reg.rows)))
               && (left ? (cur_reg.col != '0) : (10'(cur_reg.col) + 10'd2 <= 10'(cur_reg.cols)));
        s00 = $signed({5'b0, h00});
        s01 = $signed({5'b0, h01});
        s10 = $signed({5'b0, h10});
        s11 = $signed({5'b0, h11});
        d1  = s01 - s00;
        d2  = s11 - s00;
        d3  = s10 - s00;
        fx  = tri2 ? 13'sd3 * (d3 - d2) : -(13'sd3 * d1);
        fz  = tri2 ? 13'sd3 * d3 : 13'sd3 * (d2 - d1);
        fdy = tri2 ? 13'sd3 * (s11 - s10) : 13'sd3 * d1;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) nu_vec[k] = '0;
        unique case (state_reg)
            hmnt_pkg::BK_FACE: begin
                nu_vec[0] = 32'(fx);
                nu_vec[1] = hmnt_pkg::VEC_Y_FACE;
                nu_vec[2] = 32'(fz);
            end
            hmnt_pkg::BK_ACC: begin
                for (int k = 0; k < 3; k++) nu_vec[k] = 32'(acc_reg[k]);
            end
            hmnt_pkg::BK_TAN: begin
                nu_vec[0] = hmnt_pkg::VEC_X_TAN;
                nu_vec[1] = 32'(tdy_reg);
            end
            hmnt_pkg::BK_BIN: begin
                for (int k = 0; k < 3; k++) nu_vec[k] = cr_reg[k];
            end
            default: ;
        endcase
    end

    hmnt_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (nu_start),
        .vec_in  (nu_vec),
        .done    (nu_done),
        .vec_out (nu_out)
    );

    // cross product terms, one multiply per cycle
    always_comb begin
        case (cnt_reg[2:0])
            3'd0:    begin pa = nrm_reg[1]; pb = tan_reg[2]; end
            3'd1:    begin pa = nrm_reg[2]; pb = tan_reg[1]; end
            3'd2:    begin pa = nrm_reg[2]; pb = tan_reg[0]; end
            3'd3:    begin pa = nrm_reg[0]; pb = tan_reg[2]; end
            3'd4:    begin pa = nrm_reg[0]; pb = tan_reg[1]; end
            default: begin pa = nrm_reg[1]; pb = tan_reg[0]; end
        endcase
        cr_idx = 2'((cnt_reg - 4'd1) >> 1);
    end

    assign pos_x = 22'(h_reg[4]) * 22'(hmnt_pkg::POS_SCALE) + 22'(hmnt_pkg::POS_ROUND);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= hmnt_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        nu_start   = 1'b0;
        unique case (state_reg)
            hmnt_pkg::BK_IDLE: begin
                pop = valid;
                if (valid && entry.func == hmnt_pkg::FUNC_QUERY && !entry.bad) begin
                    state_next = hmnt_pkg::BK_READ;
                end
            end
            hmnt_pkg::BK_READ: begin
                if (cnt_reg == 4'd9) state_next = hmnt_pkg::BK_FACE;
            end
            hmnt_pkg::BK_FACE: begin
                if (face_ok) begin
                    nu_start   = 1'b1;
                    state_next = hmnt_pkg::BK_FWAIT;
                end else if (cnt_reg == 4'd5) begin
                    state_next = hmnt_pkg::BK_ACC;
                end
            end
            hmnt_pkg::BK_FWAIT: begin
                if (nu_done) begin
                    state_next = (cnt_reg == 4'd5) ? hmnt_pkg::BK_ACC : hmnt_pkg::BK_FACE;
                end
            end
            hmnt_pkg::BK_ACC: begin
                nu_start   = 1'b1;
                state_next = hmnt_pkg::BK_AWAIT;
            end
            hmnt_pkg::BK_AWAIT: begin
                if (nu_done) state_next = hmnt_pkg::BK_TAN;
            end
            hmnt_pkg::BK_TAN: begin
                nu_start   = 1'b1;
                state_next = hmnt_pkg::BK_TWAIT;
            end
            hmnt_pkg::BK_TWAIT: begin
                if (nu_done) state_next = hmnt_pkg::BK_CROSS;
            end
            hmnt_pkg::BK_CROSS: begin
                if (cnt_reg == 4'd6) state_next = hmnt_pkg::BK_BIN;
            end
            hmnt_pkg::BK_BIN: begin
                nu_start   = 1'b1;
                state_next = hmnt_pkg::BK_BWAIT;
            end
            hmnt_pkg::BK_BWAIT: begin
                if (nu_done) state_next = hmnt_pkg::BK_IDLE;
            end
            default: state_next = hmnt_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            out_valid_reg <= 1'b0;
            case (state_reg)
                hmnt_pkg::BK_IDLE: begin
                    cnt_reg <= '0;
                    if (valid && entry.func == hmnt_pkg::FUNC_QUERY && entry.bad) begin
                        out_valid_reg <= 1'b1;
                    end
                end
                hmnt_pkg::BK_READ: begin
                    cnt_reg <= (cnt_reg == 4'd9) ? 4'd0 : cnt_reg + 4'd1;
                end
                hmnt_pkg::BK_FACE: begin
                    if (!face_ok) cnt_reg <= cnt_reg + 4'd1;
                end
                hmnt_pkg::BK_FWAIT: begin
                    if (nu_done) cnt_reg <= cnt_reg + 4'd1;
                end
                hmnt_pkg::BK_ACC: cnt_reg <= '0;
                hmnt_pkg::BK_CROSS: begin
                    cnt_reg <= (cnt_reg == 4'd6) ? 4'd0 : cnt_reg + 4'd1;
                end
                hmnt_pkg::BK_BWAIT: begin
                    if (nu_done) out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        case (state_reg)
            hmnt_pkg::BK_IDLE: begin
                if (valid) cur_reg <= entry;
                if (valid && entry.func == hmnt_pkg::FUNC_QUERY) begin
                    acc_reg[0] <= '0;
                    acc_reg[1] <= hmnt_pkg::ACC_Y_INIT;
                    acc_reg[2] <= '0;
                    tdy_reg    <= '0;
                    if (entry.bad) begin
                        bad_reg <= 1'b1;
                        pos_reg <= '0;
                        for (int k = 0; k < 3; k++) begin
                            nrm_reg[k] <= '0;
                            tan_reg[k] <= '0;
                            bin_reg[k] <= '0;
                        end
                    end
                end
            end
            hmnt_pkg::BK_READ: begin
                if (cnt_reg != '0) h_reg[cnt_reg - 4'd1] <= rdata_reg;
            end
            hmnt_pkg::BK_FACE: begin
                // the last adjacent triangle launched supplies the tangent
                if (face_ok) tdy_reg <= fdy;
            end
            hmnt_pkg::BK_FWAIT: begin
                if (nu_done) begin
                    for (int k = 0; k < 3; k++) acc_reg[k] <= acc_reg[k] + 18'(nu_out[k]);
                end
            end
            hmnt_pkg::BK_ACC: begin
                pos_prod_reg <= 45'(pos_x) * 45'(hmnt_pkg::POS_RECIP);
            end
            hmnt_pkg::BK_AWAIT: begin
                if (nu_done) nrm_reg <= nu_out;
            end
            hmnt_pkg::BK_TWAIT: begin
                if (nu_done) tan_reg <= nu_out;
            end
            hmnt_pkg::BK_CROSS: begin
                if (cnt_reg < 4'd6) prod_reg <= 32'(pa * pb);
                if (cnt_reg != '0) begin
                    if (cnt_reg[0]) cr_reg[cr_idx] <= prod_reg;
                    else            cr_reg[cr_idx] <= cr_reg[cr_idx] - prod_reg;
                end
            end
            hmnt_pkg::BK_BWAIT: begin
                if (nu_done) begin
                    bin_reg <= nu_out;
                    bad_reg <= 1'b0;
                    pos_reg <= pos_prod_reg[hmnt_pkg::POS_SHIFT +: 15];
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pos_y     = pos_reg;
    assign normal    = nrm_reg;
    assign tangent   = tan_reg;
    assign binormal  = bin_reg;
    assign bad_query = bad_reg;

`ifndef ASSERT_OFF
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == hmnt_pkg::BK_IDLE)
        else $error("store written outside idle");
    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        nu_done |-> (state_reg == hmnt_pkg::BK_FWAIT || state_reg == hmnt_pkg::BK_AWAIT
                  || state_reg == hmnt_pkg::BK_TWAIT || state_reg == hmnt_pkg::BK_BWAIT))
        else $error("normalizer finished with no waiter");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($past(state_reg) == hmnt_pkg::BK_IDLE
                        || $past(state_reg) == hmnt_pkg::BK_BWAIT))
        else $error("result strobe from unexpected state");
`endif

endmodule

FILE: hdl/heightmap_normal_tangent_core.sv
// ----------------------------------------------------------------------------
// heightmap_normal_tangent_core
// Height store with per-vertex normal, tangent and binormal queries.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start when busy is low: func 0 loads height_byte at
//   (row, col), func 1 queries vertex (row, col). Grid size is set through
//   the cfg_valid/cfg_ready/cfg_index/cfg_data port (index 0 columns,
//   index 1 rows); the user must set it only while the block is idle;
//   the block itself does not enforce this. A two-entry queue sits
//   between the accepting front end and the back end; busy is high while
//   the queue is full. A load causes no result and is written to the
//   store as it leaves the queue. A query outside the grid gives a result
//   with bad_query set in the cycle after it leaves the queue. An in-grid
//   query runs nine store reads, then up to nine passes through the shared
//   normalizer (each pass runs its normalizing shifts, a bit-serial square
//   root and a 16-step divider per component) plus a cross product.
//   Each result is shown for exactly one cycle with out_valid high; the
//   receiver cannot hold it off.
//   Reset clears the queue, the sequencers and sets both grid sizes to 256;
//   the height store is not cleared and must be loaded before it is read.
// ----------------------------------------------------------------------------
module heightmap_normal_tangent_core #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [7:0]  row,
    input  logic [7:0]  col,
    input  logic [7:0]  height_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output logic        out_valid,
    output logic [14:0] pos_y,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic signed [15:0] tangent_x,
    output logic signed [15:0] tangent_y,
    output logic signed [15:0] tangent_z,
    output logic signed [15:0] binormal_x,
    output logic signed [15:0] binormal_y,
    output logic signed [15:0] binormal_z,
    output logic        bad_query
);

    logic            full;
    logic            push;
    logic            q_valid;
    logic            pop;
    hmnt_pkg::item_t fr_item;
    hmnt_pkg::item_t q_item;
    hmnt_pkg::comp_t nrm [3];
    hmnt_pkg::comp_t tan [3];
    hmnt_pkg::comp_t bin [3];

    assign busy = full;

    hmnt_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .row         (row),
        .col         (col),
        .height_byte (height_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .full        (full),
        .push        (push),
        .item        (fr_item)
    );

    hmnt_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (fr_item),
        .full  (full),
        .pop   (pop),
        .valid (q_valid),
        .dout  (q_item)
    );

    hmnt_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (q_valid),
        .entry     (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .pos_y     (pos_y),
        .normal    (nrm),
        .tangent   (tan),
        .binormal  (bin),
        .bad_query (bad_query)
    );

    assign normal_x   = nrm[0];
    assign normal_y   = nrm[1];
    assign normal_z   = nrm[2];
    assign tangent_x  = tan[0];
    assign tangent_y  = tan[1];
    assign tangent_z  = tan[2];
    assign binormal_x = bin[0];
    assign binormal_y = bin[1];
    assign binormal_z = bin[2];

endmodule
